// ----- hdl/afe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_pkg
// shared types and constants of the frame encoder: frame marker bytes and
// the burst of bytes that one payload byte expands to
// ----------------------------------------------------------------------------
package afe_pkg;

    localparam int          BURST_MAX = 5;
    localparam int          IDX_W     = 3;

    localparam logic [7:0]  START_DELIM = 8'h7E;
    localparam logic [7:0]  LEN_HIGH    = 8'h00;
    localparam logic [7:0]  SUM_INIT    = 8'hFF;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        idx_t                      count;
        logic                      ends_frame;
    } burst_t;

endpackage

// ----- hdl/afe_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afe_framer
// holds the frame-open flag and running checksum and expands one payload
// byte into its burst of header, data and checksum bytes
// ----------------------------------------------------------------------------
module afe_framer
    import afe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] payload_byte,
    input  logic [7:0] frame_length,
    input  logic       last_byte,
    output burst_t     burst
);

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic       frame_open_reg;
    logic       frame_open_next;
    logic [7:0] sum_base;
    logic [7:0] sum_after;

    assign sum_base  = frame_open_reg ? running_sum_reg : SUM_INIT;
    assign sum_after = sum_base - payload_byte;

    always_comb
    begin
        burst            = '0;
        running_sum_next = running_sum_reg;
        frame_open_next  = frame_open_reg;
        if (!frame_open_reg)
        begin
            burst.bytes[0] = START_DELIM;
            burst.bytes[1] = LEN_HIGH;
            burst.bytes[2] = frame_length;
            if (frame_length == 8'd0)
            begin
                // empty frame: header and checksum only, payload ignored
                burst.bytes[3]   = SUM_INIT;
                burst.count      = idx_t'(4);
                burst.ends_frame = 1'b1;
                running_sum_next = SUM_INIT;
                frame_open_next  = 1'b0;
            end
            else if (last_byte)
            begin
                burst.bytes[3]   = payload_byte;
                burst.bytes[4]   = sum_after;
                burst.count      = idx_t'(5);
                burst.ends_frame = 1'b1;
                running_sum_next = SUM_INIT;
                frame_open_next  = 1'b0;
            end
            else
            begin
                burst.bytes[3]   = payload_byte;
                burst.count      = idx_t'(4);
                running_sum_next = sum_after;
                frame_open_next  = 1'b1;
            end
        end
        else
        begin
            burst.bytes[0] = payload_byte;
            if (last_byte)
            begin
                burst.bytes[1]   = sum_after;
                burst.count      = idx_t'(2);
                burst.ends_frame = 1'b1;
                running_sum_next = SUM_INIT;
                frame_open_next  = 1'b0;
            end
            else
            begin
                burst.count      = idx_t'(1);
                running_sum_next = sum_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= SUM_INIT;
            frame_open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            running_sum_reg <= running_sum_next;
            frame_open_reg  <= frame_open_next;
        end
    end

endmodule

// ----- hdl/api_frame_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_encoder_core
// length-prefixed frame encoder: payload bytes in, serial frame bytes out
// a request's first byte goes through the burst register, then the output register
// throughput: 1 to 5 bytes per request through the single-byte output register;
//   plain data bytes go 1 per cycle unless m_axis_tready stalls the output
// reset: no frame open, checksum at 0xFF, burst and output registers empty
// ----------------------------------------------------------------------------
module api_frame_encoder_core
    import afe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // payload_byte[7:0], frame_length[15:8]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
    output logic        m_axis_tlast,   // last_of_run
    output logic        m_axis_tuser    // frame_done
);

    burst_t     burst_new;
    burst_t     burst_reg;
    logic       burst_valid_reg;
    idx_t       burst_idx_reg;
    logic       accept;
    logic       pop;
    logic       at_end;
    logic       pop_last;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic       out_valid_reg;

    afe_framer u_framer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (s_axis_tdata[7:0]),
        .frame_length (s_axis_tdata[15:8]),
        .last_byte    (s_axis_tlast),
        .burst        (burst_new)
    );

    assign pop           = burst_valid_reg && (!out_valid_reg || m_axis_tready);
    assign at_end        = (burst_idx_reg == burst_reg.count - idx_t'(1));
    assign pop_last      = pop && at_end;
    assign s_axis_tready = !burst_valid_reg || pop_last;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // burst buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            burst_idx_reg   <= '0;
        end
        else if (accept)
        begin
            burst_valid_reg <= 1'b1;
            burst_idx_reg   <= '0;
        end
        else if (pop_last)
        begin
            burst_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            burst_idx_reg <= burst_idx_reg + idx_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            burst_reg <= burst_new;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= burst_reg.bytes[burst_idx_reg];
            out_last_reg <= at_end;
            out_done_reg <= at_end && burst_reg.ends_frame;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (burst_idx_reg < burst_reg.count))
        else $error("burst index beyond burst length");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (burst_reg.count != idx_t'(0) &&
                             burst_reg.count <= idx_t'(BURST_MAX)))
        else $error("burst length out of range");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("checksum byte not last of its request");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg && !pop |=> burst_valid_reg && $stable(burst_idx_reg))
        else $error("burst lost while output stalled");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for api_frame_encoder_core: payload bytes go in as
// requests in random bursts while the output side stalls on patterns of its
// own; every output byte is compared with a software copy of the framing
// (delimiter, length, data, checksum) kept request by request
// ----------------------------------------------------------------------------
module tb;
    import afe_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
        logic       frame_done;
    } tx_result_t;

    class frame_stream_model;
        logic [7:0]  running_sum;
        logic        frame_open;
        tx_result_t  expected_tx[$];
        int unsigned failures;

        function new();
            running_sum = SUM_INIT;
            frame_open  = 1'b0;
            failures    = 0;
        endfunction

        function void queue_byte(logic [7:0] value, logic done);
            tx_result_t r;
            r.tx_byte     = value;
            r.last_of_run = 1'b0;
            r.frame_done  = done;
            expected_tx.push_back(r);
        endfunction

        function void mark_run_end();
            expected_tx[expected_tx.size() - 1].last_of_run = 1'b1;
        endfunction

        function void note_payload(logic [7:0] data, logic [7:0] len, logic last);
            if (!frame_open)
            begin
                queue_byte(START_DELIM, 1'b0);
                queue_byte(LEN_HIGH, 1'b0);
                queue_byte(len, 1'b0);
                running_sum = SUM_INIT;
                // empty frame: header plus checksum, payload byte dropped
                if (len == 8'h00)
                begin
                    queue_byte(SUM_INIT, 1'b1);
                    mark_run_end();
                    return;
                end
                frame_open = 1'b1;
            end
            queue_byte(data, 1'b0);
            running_sum = running_sum - data;
            if (last)
            begin
                queue_byte(running_sum, 1'b1);
                frame_open  = 1'b0;
                running_sum = SUM_INIT;
            end
            mark_run_end();
        endfunction

        function void check_tx(logic [7:0] tx_byte, logic last_of_run, logic frame_done);
            tx_result_t want;
            if (expected_tx.size() == 0)
            begin
                $display("%0t: unexpected output: expected none, got byte %02h last %0b done %0b",
                         $time, tx_byte, last_of_run, frame_done);
                failures++;
                return;
            end
            want = expected_tx.pop_front();
            if (tx_byte !== want.tx_byte)
            begin
                $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                         $time, want.tx_byte, tx_byte);
                failures++;
            end
            if (last_of_run !== want.last_of_run)
            begin
                $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                         $time, want.last_of_run, last_of_run);
                failures++;
            end
            if (frame_done !== want.frame_done)
            begin
                $display("%0t: frame_done mismatch: expected %0b, got %0b",
                         $time, want.frame_done, frame_done);
                failures++;
            end
        endfunction

        function int pending();
            return expected_tx.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // payload_byte[7:0], frame_length[15:8]
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // tx_byte[7:0]
    logic        m_axis_tlast;   // last_of_run
    logic        m_axis_tuser;   // frame_done

    frame_stream_model frame_model;
    int unsigned       sent_items;
    int unsigned       burst_left;
    int unsigned       idle_cycles;
    int unsigned       stall_left;
    int unsigned       stall_mode;
    int unsigned       rx_cycle;

    api_frame_encoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // output side stall patterns, each held for a random stretch
    always @(negedge clk)
    begin
        rx_cycle++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_cycle % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                frame_model.note_payload(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                frame_model.check_tx(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_payload(input logic [7:0] data, input logic [7:0] len,
                                input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, data};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
        burst_left--;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // len goes in the header; count bytes follow, the final one marked last
    task automatic send_frame(input logic [7:0] len, input int unsigned count);
        logic [7:0] ignored_len;
        send_payload(8'($urandom_range(0, 255)), len, count == 1);
        for (int unsigned i = 1; i < count; i++)
        begin
            ignored_len = 8'($urandom_range(0, 255));
            send_payload(8'($urandom_range(0, 255)), ignored_len, i == count - 1);
        end
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned count;
        frame_model   = new();
        sent_items    = 0;
        burst_left    = 3;
        idle_cycles   = 0;
        stall_left    = 0;
        stall_mode    = 0;
        rx_cycle      = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0000;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty frames, last marker ignored either way
        send_payload(8'hA5, 8'h00, 1'b0);
        send_payload(8'h00, 8'h00, 1'b1);
        // one-byte frames, length matching and not
        send_payload(8'h00, 8'h01, 1'b1);
        send_payload(8'hFF, 8'hFF, 1'b1);
        // length field ignored while open, zero included
        send_payload(8'h01, 8'h03, 1'b0);
        send_payload(8'h80, 8'hFF, 1'b0);
        send_payload(8'h7E, 8'h00, 1'b1);
        // frame closed before its stated length
        send_payload(8'hFF, 8'h10, 1'b0);
        send_payload(8'hFF, 8'h10, 1'b1);
        send_payload(8'h55, 8'hFF, 1'b0);
        send_payload(8'hAA, 8'h00, 1'b0);
        send_payload(8'h7D, 8'h01, 1'b0);
        send_payload(8'h11, 8'h00, 1'b1);
        // empty frame right after a close
        send_payload(8'hFF, 8'h00, 1'b1);
        send_payload(8'h80, 8'h80, 1'b0);
        send_payload(8'h7F, 8'h7F, 1'b1);

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_payload(8'($urandom_range(0, 255)), 8'h00, 1'($urandom_range(0, 1)));
            else if (pick < 70)
            begin
                count = $urandom_range(1, 8);
                send_frame(8'(count), count);
            end
            else if (pick < 90)
                send_frame(8'($urandom_range(1, 255)), $urandom_range(1, 6));
            else
                send_payload(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        while (frame_model.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (frame_model.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
